// ===== rtl/core/aas_pkg.sv =====
// Shared types, constants and helpers of the annealing acceptance block.
package aas_pkg;

   localparam int DEF_STEP_BITS      = 32;
   localparam int DEF_REHEAT_EPOCH   = 100000;
   localparam int DEF_TEMP_FRAC_BITS = 16;

   localparam int VIOL_W   = 16;
   localparam int COST_W   = 20;
   localparam int SAMPLE_W = 18;
   localparam int SCORE_W  = 23;
   localparam int TEMP_W   = 40;
   localparam int PROB_W   = 17;
   localparam int STEP_W   = 32;
   localparam int MODE_W   = 3;
   localparam int REM_W    = 17;
   localparam int LN_W     = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int DIV_W     = 64;
   localparam int DVS_W     = 40;
   localparam int DIV_CNT_W = 7;
   localparam logic [DIV_CNT_W-1:0] DIV_FULL  = 7'd64;
   localparam logic [DIV_CNT_W-1:0] DIV_SHORT = 7'd40;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0]        SCORE_WEIGHT = 7'd100;
   localparam logic [TEMP_W-1:0] TEMP_INF  = 40'hFF_FFFF_FFFF;
   localparam logic [TEMP_W-1:0] TEMP_TOP  = 40'hFF_FFFF_FFFE;
   localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
   localparam logic [15:0]       BETA_GAP  = 16'd42950;
   localparam logic [31:0]       EXPM1_Q32 = 32'd1580030169;
   localparam logic [9:0]        START_INT = 10'd1000;
   localparam logic [PROB_W-1:0] PROB_ONE  = 17'h10000;
   localparam logic [3:0]        EXP_TERMS = 4'd13;
   localparam logic [3:0]        EXP_Q_LIMIT = 4'd12;
   localparam logic [22:0]       LOG_C50 = 23'd50;
   localparam logic [22:0]       LOG_C1  = 23'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_VIOL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COST = 2'd2;

   // schedule modes
   localparam logic [MODE_W-1:0] MODE_ZERO    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOG50   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOG1    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOGINIT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_GEO     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REHEAT  = 3'd5;

   typedef enum logic [1:0] {
      SCH_ZERO,
      SCH_LOG,
      SCH_GEO,
      SCH_REHEAT
   } sched_type;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_TEMP,
      BK_NORM,
      BK_SQUARE,
      BK_LNMUL,
      BK_LNDIV,
      BK_LNWAIT,
      BK_PROB,
      BK_RWAIT,
      BK_TERM,
      BK_TWAIT,
      BK_PDIV,
      BK_PWAIT,
      BK_SCALE,
      BK_DECIDE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [VIOL_W-1:0]          cv;
      logic [COST_W-1:0]          cc;
      logic signed [SAMPLE_W-1:0] sample;
      logic [SCORE_W-1:0]         score;
      logic [STEP_W-1:0]          step;
      sched_type                  kind;
      logic [SCORE_W-1:0]         c;
      logic [TEMP_W-1:0]          geo;
      logic [TEMP_W-1:0]          rht;
   } entry_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_W-1:0]       dividend;
      logic [DVS_W-1:0]       divisor;
      logic [DIV_CNT_W-1:0]   nbits;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [SCORE_W-1:0] calc_score(input logic [VIOL_W-1:0] v,
                                                     input logic [COST_W-1:0] c);
      logic [SCORE_W:0] s;
      s = 24'(v) * 24'(SCORE_WEIGHT) + 24'(c);
      return s[SCORE_W-1:0];
   endfunction

endpackage

// ===== rtl/core/aas_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend aligned to the top.
module aas_div (
   input  logic                 clock,
   input  logic                 reset,
   input  aas_pkg::div_req_type req,
   output aas_pkg::div_rsp_type rsp
);
   import aas_pkg::*;

   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       rsh;
   logic                 ge;

   assign rsh = {rem_ff, dvd_ff[DIV_W-1]};
   assign ge  = rsh >= {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = req.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         rem_in = ge ? DVS_W'(rsh - {1'b0, dvs_ff}) : rsh[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

// ===== rtl/core/aas_queue.sv =====
// Short queue of classified moves between front and back.
module aas_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aas_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output aas_pkg::entry_type pop_data
);
   import aas_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign full      = cnt_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];

endmodule

// ===== rtl/core/aas_front.sv =====
// Front end: takes moves, scores them, steps the schedules, classifies the mode.
module aas_front #(
   parameter int STEP_BITS      = aas_pkg::DEF_STEP_BITS,
   parameter int REHEAT_EPOCH   = aas_pkg::DEF_REHEAT_EPOCH,
   parameter int TEMP_FRAC_BITS = aas_pkg::DEF_TEMP_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic [aas_pkg::MODE_W-1:0]         mode,
   input  logic [aas_pkg::SCORE_W-1:0]        init_score,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [aas_pkg::VIOL_W-1:0]         req_candidate_violations,
   input  logic [aas_pkg::COST_W-1:0]         req_candidate_costs,
   input  logic signed [aas_pkg::SAMPLE_W-1:0] req_threshold_sample,
   input  logic                               queue_full,
   output logic                               push,
   output aas_pkg::entry_type                 push_data
);
   import aas_pkg::*;

   localparam int CNT_W = (STEP_BITS < STEP_W) ? STEP_BITS : STEP_W;
   localparam int POS_W = $clog2(REHEAT_EPOCH + 1);
   localparam logic [63:0]       START_FULL = 64'(START_INT) << TEMP_FRAC_BITS;
   localparam logic [TEMP_W-1:0] START_TEMP = TEMP_W'(START_FULL);
   localparam logic [TEMP_W-1:0] START_LQ   = TEMP_W'(START_FULL / 64'(REHEAT_EPOCH));
   localparam logic [REM_W-1:0]  START_LR   = REM_W'(START_FULL % 64'(REHEAT_EPOCH));
   localparam logic [REM_W:0]    EPOCH_EXT  = (REM_W+1)'(REHEAT_EPOCH);
   localparam logic [POS_W-1:0]  EPOCH_LAST = POS_W'(REHEAT_EPOCH - 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TEMP_W-1:0] geo_ff, geo_in;
   logic [TEMP_W-1:0] lvl_ff, lvl_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [TEMP_W-1:0] rht_ff, rht_in;
   logic [REM_W-1:0]  rhr_ff, rhr_in;
   logic [TEMP_W-1:0] lq_ff, lq_in;
   logic [REM_W-1:0]  lr_ff, lr_in;
   logic [REM_W:0]    rh_diff;
   logic [REM_W:0]    lr_half;
   logic [55:0]       gmul;
   sched_type         kind;
   logic [SCORE_W-1:0] c_sel;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // geometric cooling: T -= ceil(T * gap / 2^32)
   assign gmul = 56'(geo_ff) * 56'(BETA_GAP) + 56'(32'hFFFF_FFFF);

   // Reheat temperature level*rem/epoch kept as quotient and remainder;
   // level itself is kept split the same way, so each step only subtracts.
   assign rh_diff = {1'b0, rhr_ff} - {1'b0, lr_ff};
   assign lr_half = ({1'b0, lr_ff} + (lq_ff[0] ? EPOCH_EXT : '0)) >> 1;

   always_comb begin
      cnt_in = (cnt_ff != '1) ? CNT_W'(cnt_ff + 1'b1) : cnt_ff;
      geo_in = geo_ff - {16'd0, gmul[55:32]};
      lvl_in = lvl_ff;
      lq_in  = lq_ff;
      lr_in  = lr_ff;
      pos_in = POS_W'(pos_ff + 1'b1);
      if (rh_diff[REM_W]) begin
         rhr_in = REM_W'(rh_diff + EPOCH_EXT);
         rht_in = rht_ff - lq_ff - 1'b1;
      end else begin
         rhr_in = rh_diff[REM_W-1:0];
         rht_in = rht_ff - lq_ff;
      end
      // end of epoch: halve the level and start again from the full level
      if (pos_ff == EPOCH_LAST) begin
         pos_in = '0;
         lvl_in = lvl_ff >> 1;
         lq_in  = lq_ff >> 1;
         lr_in  = lr_half[REM_W-1:0];
         rht_in = lvl_ff >> 1;
         rhr_in = '0;
      end
   end

   always_comb begin
      kind  = SCH_ZERO;
      c_sel = '0;
      case (mode)
         MODE_LOG50: begin
            kind  = SCH_LOG;
            c_sel = LOG_C50;
         end
         MODE_LOG1: begin
            kind  = SCH_LOG;
            c_sel = LOG_C1;
         end
         MODE_LOGINIT: begin
            kind  = (init_score != '0) ? SCH_LOG : SCH_ZERO;
            c_sel = init_score;
         end
         MODE_GEO:    kind = SCH_GEO;
         MODE_REHEAT: kind = SCH_REHEAT;
         default:     kind = SCH_ZERO;
      endcase
   end

   always_comb begin
      push_data.cv     = req_candidate_violations;
      push_data.cc     = req_candidate_costs;
      push_data.sample = req_threshold_sample;
      push_data.score  = calc_score(req_candidate_violations, req_candidate_costs);
      push_data.step   = STEP_W'(cnt_in);
      push_data.kind   = kind;
      push_data.c      = c_sel;
      push_data.geo    = geo_ff;
      push_data.rht    = rht_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         cnt_ff <= '0;
         geo_ff <= START_TEMP;
         lvl_ff <= START_TEMP;
         pos_ff <= '0;
         rht_ff <= START_TEMP;
         rhr_ff <= '0;
         lq_ff  <= START_LQ;
         lr_ff  <= START_LR;
      end else if (push) begin
         cnt_ff <= cnt_in;
         geo_ff <= geo_in;
         lvl_ff <= lvl_in;
         pos_ff <= pos_in;
         rht_ff <= rht_in;
         rhr_ff <= rhr_in;
         lq_ff  <= lq_in;
         lr_ff  <= lr_in;
      end
   end

endmodule

// ===== rtl/core/aas_back.sv =====
// Back end: temperature, exp(-delta/T) sequencer, decision and result register.
module aas_back #(
   parameter int TEMP_FRAC_BITS = aas_pkg::DEF_TEMP_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [aas_pkg::VIOL_W-1:0]    init_viol,
   input  logic [aas_pkg::COST_W-1:0]    init_cost,
   input  logic                          entry_valid,
   input  aas_pkg::entry_type            entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [aas_pkg::STEP_W-1:0]    rsp_step_number,
   output logic [aas_pkg::VIOL_W-1:0]    rsp_kept_violations,
   output logic [aas_pkg::COST_W-1:0]    rsp_kept_costs,
   output logic [aas_pkg::TEMP_W-1:0]    rsp_step_temperature,
   output logic [aas_pkg::PROB_W-1:0]    rsp_accept_probability
);
   import aas_pkg::*;

   localparam int SH = TEMP_FRAC_BITS + 16;

   back_state_type    state_ff, state_in;
   entry_type         ent_ff, ent_in;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic [31:0]       x_ff, x_in;
   logic [4:0]        e_ff, e_in;
   logic [LN_W-1:0]   l2_ff, l2_in;
   logic [3:0]        bit_ff, bit_in;
   logic [LN_W-1:0]   ln_ff, ln_in;
   logic [15:0]       f_ff, f_in;
   logic [3:0]        q_ff, q_in;
   logic [32:0]       term_ff, term_in;
   logic [35:0]       sum_ff, sum_in;
   logic [3:0]        n_ff, n_in;
   logic [31:0]       p_ff, p_in;
   logic [PROB_W-1:0] prob_ff, prob_in;
   logic              acc_ff, acc_in;
   logic [VIOL_W-1:0]  best_v_ff, best_v_in;
   logic [COST_W-1:0]  best_c_ff, best_c_in;
   logic [SCORE_W-1:0] best_s_ff, best_s_in;
   logic              ov_ff, ov_in;
   logic              o_acc_ff, o_acc_in;
   logic [STEP_W-1:0] o_step_ff, o_step_in;
   logic [VIOL_W-1:0] o_kv_ff, o_kv_in;
   logic [COST_W-1:0] o_kc_ff, o_kc_in;
   logic [TEMP_W-1:0] o_temp_ff, o_temp_in;
   logic [PROB_W-1:0] o_prob_ff, o_prob_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [63:0]        sq;
   logic [52:0]        lnp;
   logic [48:0]        tp;
   logic [63:0]        pm;
   logic [32:0]        pr;
   logic [SCORE_W-1:0] delta;

   aas_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign sq      = 64'(x_ff) * 64'(x_ff);
   assign lnp     = 53'(l2_ff) * 53'(LN2_Q32);
   assign tp      = 49'(term_ff) * 49'(f_ff);
   assign pm      = 64'(p_ff) * 64'(EXPM1_Q32);
   assign pr      = {1'b0, p_ff} + 33'h8000;
   assign delta   = ent_ff.score - best_s_ff;

   always_comb begin
      state_in  = state_ff;
      ent_in    = ent_ff;
      temp_in   = temp_ff;
      x_in      = x_ff;
      e_in      = e_ff;
      l2_in     = l2_ff;
      bit_in    = bit_ff;
      ln_in     = ln_ff;
      f_in      = f_ff;
      q_in      = q_ff;
      term_in   = term_ff;
      sum_in    = sum_ff;
      n_in      = n_ff;
      p_in      = p_ff;
      prob_in   = prob_ff;
      acc_in    = acc_ff;
      best_v_in = best_v_ff;
      best_c_in = best_c_ff;
      best_s_in = best_s_ff;
      ov_in     = ov_ff && !rsp_ready;
      o_acc_in  = o_acc_ff;
      o_step_in = o_step_ff;
      o_kv_in   = o_kv_ff;
      o_kc_in   = o_kc_ff;
      o_temp_in = o_temp_ff;
      o_prob_in = o_prob_ff;
      pop       = 1'b0;
      div_req   = '{start: 1'b0, dividend: '0, divisor: '0, nbits: DIV_FULL};

      case (state_ff)
         BK_IDLE: begin
            if (entry_valid) begin
               pop      = 1'b1;
               ent_in   = entry;
               state_in = BK_TEMP;
            end
         end
         BK_TEMP: begin
            case (ent_ff.kind)
               SCH_GEO: begin
                  temp_in  = ent_ff.geo;
                  state_in = BK_PROB;
               end
               SCH_REHEAT: begin
                  temp_in  = ent_ff.rht;
                  state_in = BK_PROB;
               end
               SCH_LOG: begin
                  x_in     = ent_ff.step;
                  e_in     = 5'd31;
                  state_in = BK_NORM;
               end
               default: begin
                  temp_in  = '0;
                  state_in = BK_PROB;
               end
            endcase
         end
         // find the integer part of log2 by shifting the step up to bit 31
         BK_NORM: begin
            if (x_ff[31]) begin
               l2_in    = {e_ff, 16'd0};
               bit_in   = 4'd15;
               state_in = BK_SQUARE;
            end else begin
               x_in = {x_ff[30:0], 1'b0};
               e_in = e_ff - 1'b1;
            end
         end
         // one fraction bit of log2 per squaring
         BK_SQUARE: begin
            if (sq[63]) begin
               x_in  = sq[63:32];
               l2_in = l2_ff | (LN_W'(1) << bit_ff);
            end else begin
               x_in = sq[62:31];
            end
            if (bit_ff == 4'd0) begin
               state_in = BK_LNMUL;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         BK_LNMUL: begin
            ln_in    = lnp[52:32];
            state_in = BK_LNDIV;
         end
         BK_LNDIV: begin
            if (ln_ff == '0) begin
               temp_in  = TEMP_INF;
               state_in = BK_PROB;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = 64'(ent_ff.c) << SH;
               div_req.divisor  = DVS_W'(ln_ff);
               state_in         = BK_LNWAIT;
            end
         end
         BK_LNWAIT: begin
            if (div_rsp.done) begin
               temp_in  = (div_rsp.quot > 64'(TEMP_TOP)) ? TEMP_TOP
                                                         : div_rsp.quot[TEMP_W-1:0];
               state_in = BK_PROB;
            end
         end
         BK_PROB: begin
            if (ent_ff.score <= best_s_ff) begin
               prob_in  = PROB_ONE;
               acc_in   = 1'b1;
               state_in = BK_DONE;
            end else if (temp_ff == TEMP_INF) begin
               prob_in  = PROB_ONE;
               state_in = BK_DECIDE;
            end else if (temp_ff == '0) begin
               prob_in  = '0;
               state_in = BK_DECIDE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = 64'(delta) << SH;
               div_req.divisor  = temp_ff;
               state_in         = BK_RWAIT;
            end
         end
         BK_RWAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quot[63:16] >= 48'(EXP_Q_LIMIT)) begin
                  prob_in  = '0;
                  state_in = BK_DECIDE;
               end else begin
                  q_in     = div_rsp.quot[19:16];
                  f_in     = div_rsp.quot[15:0];
                  term_in  = 33'h1_0000_0000;
                  sum_in   = 36'h1_0000_0000;
                  n_in     = 4'd1;
                  state_in = BK_TERM;
               end
            end
         end
         // Taylor series of exp(f), each term truncated
         BK_TERM: begin
            div_req.start    = 1'b1;
            div_req.dividend = {7'd0, tp[48:16], 24'd0};
            div_req.divisor  = DVS_W'(n_ff);
            div_req.nbits    = DIV_SHORT;
            state_in         = BK_TWAIT;
         end
         BK_TWAIT: begin
            if (div_rsp.done) begin
               term_in = div_rsp.quot[32:0];
               sum_in  = sum_ff + 36'(div_rsp.quot[32:0]);
               if (n_ff == EXP_TERMS) begin
                  state_in = BK_PDIV;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = BK_TERM;
               end
            end
         end
         BK_PDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = '1;
            div_req.divisor  = DVS_W'(sum_ff);
            state_in         = BK_PWAIT;
         end
         BK_PWAIT: begin
            if (div_rsp.done) begin
               p_in     = div_rsp.quot[31:0];
               state_in = BK_SCALE;
            end
         end
         // one factor of 1/e per integer step of the exponent
         BK_SCALE: begin
            if (q_ff == 4'd0) begin
               prob_in  = pr[32:16];
               state_in = BK_DECIDE;
            end else begin
               p_in = pm[63:32];
               q_in = q_ff - 1'b1;
            end
         end
         BK_DECIDE: begin
            acc_in   = $signed({1'b0, prob_ff}) > ent_ff.sample;
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!ov_ff || rsp_ready) begin
               ov_in     = 1'b1;
               o_acc_in  = acc_ff;
               o_step_in = ent_ff.step;
               o_kv_in   = acc_ff ? ent_ff.cv : best_v_ff;
               o_kc_in   = acc_ff ? ent_ff.cc : best_c_ff;
               o_temp_in = temp_ff;
               o_prob_in = prob_ff;
               if (acc_ff) begin
                  best_v_in = ent_ff.cv;
                  best_c_in = ent_ff.cc;
                  best_s_in = ent_ff.score;
               end
               acc_in   = 1'b0;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         ov_ff     <= 1'b0;
         acc_ff    <= 1'b0;
         best_v_ff <= '0;
         best_c_ff <= '0;
         best_s_ff <= '0;
      end else if (restart) begin
         state_ff  <= BK_IDLE;
         ov_ff     <= 1'b0;
         acc_ff    <= 1'b0;
         best_v_ff <= init_viol;
         best_c_ff <= init_cost;
         best_s_ff <= calc_score(init_viol, init_cost);
      end else begin
         state_ff  <= state_in;
         ov_ff     <= ov_in;
         acc_ff    <= acc_in;
         best_v_ff <= best_v_in;
         best_c_ff <= best_c_in;
         best_s_ff <= best_s_in;
      end
      ent_ff    <= ent_in;
      temp_ff   <= temp_in;
      x_ff      <= x_in;
      e_ff      <= e_in;
      l2_ff     <= l2_in;
      bit_ff    <= bit_in;
      ln_ff     <= ln_in;
      f_ff      <= f_in;
      q_ff      <= q_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      n_ff      <= n_in;
      p_ff      <= p_in;
      prob_ff   <= prob_in;
      o_acc_ff  <= o_acc_in;
      o_step_ff <= o_step_in;
      o_kv_ff   <= o_kv_in;
      o_kc_ff   <= o_kc_in;
      o_temp_ff <= o_temp_in;
      o_prob_ff <= o_prob_in;
   end

   assign rsp_valid              = ov_ff;
   assign rsp_accepted           = o_acc_ff;
   assign rsp_step_number        = o_step_ff;
   assign rsp_kept_violations    = o_kv_ff;
   assign rsp_kept_costs         = o_kc_ff;
   assign rsp_step_temperature   = o_temp_ff;
   assign rsp_accept_probability = o_prob_ff;

endmodule

// ===== rtl/core/annealing_schedule_and_acceptance.sv =====
// A move that is no worse at a fixed temperature takes the shortest path through the back end,
//   and a worse move under a log schedule the longest; most of that is the shared
//   divider, which retires one quotient bit per cycle (64 bits per full division).
// Throughput: one word per back-end pass; the two-entry queue and the result
//   register let new words in while a result waits.
// Reset (synchronous, active high) and any write to a listed register restart the run.
module annealing_schedule_and_acceptance #(
   parameter int STEP_BITS      = aas_pkg::DEF_STEP_BITS,
   parameter int REHEAT_EPOCH   = aas_pkg::DEF_REHEAT_EPOCH,
   parameter int TEMP_FRAC_BITS = aas_pkg::DEF_TEMP_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [aas_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [aas_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [aas_pkg::VIOL_W-1:0]           req_candidate_violations,
   input  logic [aas_pkg::COST_W-1:0]           req_candidate_costs,
   input  logic signed [aas_pkg::SAMPLE_W-1:0]  req_threshold_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_accepted,
   output logic [aas_pkg::STEP_W-1:0]           rsp_step_number,
   output logic [aas_pkg::VIOL_W-1:0]           rsp_kept_violations,
   output logic [aas_pkg::COST_W-1:0]           rsp_kept_costs,
   output logic [aas_pkg::TEMP_W-1:0]           rsp_step_temperature,
   output logic [aas_pkg::PROB_W-1:0]           rsp_accept_probability
);
   import aas_pkg::*;

   // configuration registers
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [VIOL_W-1:0] viol_ff, viol_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              restart;

   logic      push, queue_full, pop, queue_ne;
   entry_type push_data, pop_data;

   // Decode the write. The back end loads the kept solution from the values
   // being written, so it sees the new start point on the same edge.
   always_comb begin
      mode_in = mode_ff;
      viol_in = viol_ff;
      cost_in = cost_ff;
      restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[MODE_W-1:0];
               restart = 1'b1;
            end
            CSR_INIT_VIOL: begin
               viol_in = csr_wdata[VIOL_W-1:0];
               restart = 1'b1;
            end
            CSR_INIT_COST: begin
               cost_in = csr_wdata[COST_W-1:0];
               restart = 1'b1;
            end
            default: restart = 1'b0; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ZERO;
         viol_ff <= '0;
         cost_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         viol_ff <= viol_in;
         cost_ff <= cost_in;
      end
   end

   // front: score the move, advance step count, geometric and reheat state
   aas_front #(
      .STEP_BITS      (STEP_BITS),
      .REHEAT_EPOCH   (REHEAT_EPOCH),
      .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
   ) u_front (
      .clock                    (clock),
      .reset                    (reset),
      .restart                  (restart),
      .mode                     (mode_ff),
      .init_score               (calc_score(viol_ff, cost_ff)),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_candidate_violations (req_candidate_violations),
      .req_candidate_costs      (req_candidate_costs),
      .req_threshold_sample     (req_threshold_sample),
      .queue_full               (queue_full),
      .push                     (push),
      .push_data                (push_data)
   );

   // hold classified moves until the back end is free
   aas_queue u_queue (
      .clock     (clock),
      .reset     (reset || restart),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_ne),
      .pop_data  (pop_data)
   );

   // back: temperature, acceptance probability, decision, result word
   aas_back #(
      .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .restart                (restart),
      .init_viol              (viol_in),
      .init_cost              (cost_in),
      .entry_valid            (queue_ne),
      .entry                  (pop_data),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_accepted           (rsp_accepted),
      .rsp_step_number        (rsp_step_number),
      .rsp_kept_violations    (rsp_kept_violations),
      .rsp_kept_costs         (rsp_kept_costs),
      .rsp_step_temperature   (rsp_step_temperature),
      .rsp_accept_probability (rsp_accept_probability)
   );

endmodule

// ===== rtl/core/aas_checker.sv =====
// Port-level checks of the annealing acceptance block, bound to the top level.
module aas_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_accepted,
   input logic [aas_pkg::STEP_W-1:0]          rsp_step_number,
   input logic [aas_pkg::TEMP_W-1:0]          rsp_step_temperature,
   input logic [aas_pkg::PROB_W-1:0]          rsp_accept_probability
);
   import aas_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_number)
                                 && $stable(rsp_accepted))
      else $error("result word dropped or changed while stalled");

   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_accept_probability <= PROB_ONE)
      else $error("probability above one");

   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_number != '0)
      else $error("step number zero");

   a_zero_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_temperature == '0 |->
         rsp_accept_probability == '0 || rsp_accept_probability == PROB_ONE)
      else $error("fractional probability at zero temperature");

endmodule

bind annealing_schedule_and_acceptance aas_checker u_aas_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_accepted           (rsp_accepted),
   .rsp_step_number        (rsp_step_number),
   .rsp_step_temperature   (rsp_step_temperature),
   .rsp_accept_probability (rsp_accept_probability)
);

// ===== test/testbench.sv =====
// Self-checking testbench of the annealing schedule and acceptance block.
`timescale 1ns / 1ps

module testbench;
   import aas_pkg::*;

   localparam int                   HALF_PERIOD = 6;
   localparam int                   STALL_LIMIT = 20000;  // cycles without any handshake
   localparam int                   HOLD_LEN    = 1500;   // long receiver hold-off
   localparam int                   TAIL_CYCLES = 900;    // worst back-end pass plus margin
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;   // index beyond the register list
   localparam logic [MODE_W-1:0]    MODE_SPARE6 = 3'd6;
   localparam logic [MODE_W-1:0]    MODE_SPARE7 = 3'd7;
   localparam int                   FRAC_SHIFT  = DEF_TEMP_FRAC_BITS + 16;
   localparam logic [63:0]          EPOCH_LEN   = 64'(DEF_REHEAT_EPOCH);
   localparam logic [63:0]          COUNT_TOP   = 64'hFFFF_FFFF;
   localparam logic [63:0]          PROB_FULL   = 64'd65536;

   typedef struct {
      logic              accepted;
      logic [STEP_W-1:0] step;
      logic [VIOL_W-1:0] viol;
      logic [COST_W-1:0] cost;
      logic [TEMP_W-1:0] temp;
      logic [PROB_W-1:0] prob;
   } move_outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [VIOL_W-1:0]          req_candidate_violations = '0;
   logic [COST_W-1:0]          req_candidate_costs = '0;
   logic signed [SAMPLE_W-1:0] req_threshold_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_accepted;
   logic [STEP_W-1:0]          rsp_step_number;
   logic [VIOL_W-1:0]          rsp_kept_violations;
   logic [COST_W-1:0]          rsp_kept_costs;
   logic [TEMP_W-1:0]          rsp_step_temperature;
   logic [PROB_W-1:0]          rsp_accept_probability;

   annealing_schedule_and_acceptance u_top (.*);

   always #HALF_PERIOD clock = ~clock;

   // Mirror of the block's registers and annealing state.
   logic [MODE_W-1:0] sched_mode;
   logic [VIOL_W-1:0] start_viol;
   logic [COST_W-1:0] start_cost;
   logic [63:0]       move_total, geo_temp, reheat_temp, epoch_pos, kept_score;
   logic [VIOL_W-1:0] kept_viol;
   logic [COST_W-1:0] kept_cost;

   move_outcome_type pending_outcomes[$];
   int            error_count = 0;
   int            words_sent = 0;
   int            words_checked = 0;
   int            uphill_accepts = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   bit            hold_request = 0;
   int            hold_left = 0;
   int            quiet_cycles = 0;

   function automatic void restart_annealing();
      move_total  = 0;
      geo_temp    = 64'd1000 << DEF_TEMP_FRAC_BITS;
      reheat_temp = 64'd1000 << DEF_TEMP_FRAC_BITS;
      epoch_pos   = 0;
      kept_viol   = start_viol;
      kept_cost   = start_cost;
      kept_score  = 64'(start_viol) * 100 + 64'(start_cost);
   endfunction

   // Natural log in Q16: log2 by repeated squaring, scaled by ln2.
   function automatic logic [63:0] ln_fixed(logic [63:0] k);
      int          e;
      logic [63:0] x, l2;
      e = 0;
      while (e < 31 && (k >> (e + 1)) != 0) e++;
      x  = k << (31 - e);
      l2 = 64'(e) << 16;
      for (int b = 15; b >= 0; b--) begin
         x = (x * x) >> 31;
         if (x >= 64'h1_0000_0000) begin
            l2 |= 64'd1 << b;
            x >>= 1;
         end
      end
      return (l2 * 64'(LN2_Q32)) >> 32;
   endfunction

   function automatic logic [63:0] log_schedule_temp(logic [63:0] c, logic [63:0] k);
      logic [63:0] ln, t;
      if (c == 0) return 0;
      ln = ln_fixed(k);
      if (ln == 0) return 64'(TEMP_INF);
      t = (c << FRAC_SHIFT) / ln;
      return (t > 64'(TEMP_TOP)) ? 64'(TEMP_TOP) : t;
   endfunction

   // exp(-r) for r in Q16, result in Q1.16 rounded.
   function automatic logic [63:0] exp_neg(logic [63:0] r);
      logic [63:0] q, f, term, sum, p;
      q    = r >> 16;
      f    = r & 64'hFFFF;
      term = 64'h1_0000_0000;
      sum  = term;
      if (q >= 12) return 0;
      for (int n = 1; n <= 13; n++) begin
         term = ((term * f) >> 16) / 64'(n);
         sum += term;
      end
      p = 64'hFFFF_FFFF_FFFF_FFFF / sum;
      for (int i = 0; i < q; i++) p = (p * 64'(EXPM1_Q32)) >> 32;
      return (p + 64'h8000) >> 16;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_MODE:      sched_mode = val[MODE_W-1:0];
         CSR_INIT_VIOL: start_viol = val[VIOL_W-1:0];
         CSR_INIT_COST: start_cost = val[COST_W-1:0];
         default:       return;
      endcase
      restart_annealing();
   endfunction

   // Advance the mirror by one move and return what the block must report.
   function automatic move_outcome_type anneal_move(logic [VIOL_W-1:0] cv,
                                                    logic [COST_W-1:0] cc,
                                                    logic signed [SAMPLE_W-1:0] sample);
      move_outcome_type o;
      logic [63:0]   score, temp, prob, delta;
      score = 64'(cv) * 100 + 64'(cc);
      if (move_total < COUNT_TOP) move_total++;
      case (sched_mode)
         MODE_LOG50:   temp = log_schedule_temp(64'(LOG_C50), move_total);
         MODE_LOG1:    temp = log_schedule_temp(64'(LOG_C1), move_total);
         MODE_LOGINIT: temp = log_schedule_temp(64'(start_viol) * 100 + 64'(start_cost),
                                                move_total);
         MODE_GEO:     temp = geo_temp;
         MODE_REHEAT:  temp = reheat_temp * (EPOCH_LEN - epoch_pos) / EPOCH_LEN;
         default:      temp = 0;
      endcase
      // geometric and reheat state advance in every mode
      geo_temp -= (geo_temp * 64'(BETA_GAP) + 64'hFFFF_FFFF) >> 32;
      epoch_pos++;
      if (epoch_pos >= EPOCH_LEN) begin
         epoch_pos   = 0;
         reheat_temp = reheat_temp >> 1;
      end
      if (score <= kept_score) begin
         prob       = PROB_FULL;
         o.accepted = 1'b1;
      end else begin
         delta = score - kept_score;
         if (temp == 64'(TEMP_INF)) prob = PROB_FULL;
         else if (temp == 0)        prob = 0;
         else                       prob = exp_neg((delta << FRAC_SHIFT) / temp);
         o.accepted = longint'(prob) > longint'(sample);
         if (o.accepted) uphill_accepts++;
      end
      if (o.accepted) begin
         kept_viol  = cv;
         kept_cost  = cc;
         kept_score = score;
      end
      o.step = move_total[STEP_W-1:0];
      o.viol = kept_viol;
      o.cost = kept_cost;
      o.temp = temp[TEMP_W-1:0];
      o.prob = prob[PROB_W-1:0];
      return o;
   endfunction

   // Offer one word, hold it until accepted, then predict and maybe idle.
   task automatic send_move(logic [VIOL_W-1:0] cv, logic [COST_W-1:0] cc,
                            logic signed [SAMPLE_W-1:0] sample);
      req_valid                <= 1'b1;
      req_candidate_violations <= cv;
      req_candidate_costs      <= cc;
      req_threshold_sample     <= sample;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(anneal_move(cv, cc, sample));
      words_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected word is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_register(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_run(logic [MODE_W-1:0] mode, logic [VIOL_W-1:0] v, logic [COST_W-1:0] c);
      write_register(CSR_MODE, CSR_DATA_W'(mode));
      write_register(CSR_INIT_VIOL, CSR_DATA_W'(v));
      write_register(CSR_INIT_COST, c);
   endtask

   // Candidate near the kept solution so that deltas land where the
   // temperature matters; a share of full-range noise covers every bit.
   task automatic send_random_move();
      int                         v, c, spread;
      logic signed [SAMPLE_W-1:0] s;
      if ($urandom_range(99) < 12) begin
         v = $urandom_range(65535);
         c = $urandom_range(1048575);
      end else begin
         case ($urandom_range(3))
            0:       spread = 8;
            1:       spread = 200;
            2:       spread = 5000;
            default: spread = 60000;
         endcase
         v = kept_viol;
         if ($urandom_range(9) < 2) v = v + $urandom_range(2) - 1;
         c = int'(kept_cost) + $urandom_range(2 * spread) - spread;
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
         if (c < 0) c = 0;
         if (c > 1048575) c = 1048575;
      end
      case ($urandom_range(9))
         0, 1, 2, 3, 4: s = SAMPLE_W'($urandom_range(65536));
         5, 6, 7:       s = SAMPLE_W'($urandom);
         default:       s = SAMPLE_W'($urandom_range(64)) - 18'sd32;
      endcase
      send_move(VIOL_W'(v), COST_W'(c), s);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Result side: check each word, then pick the next ready level.
   always @(posedge clock) begin
      move_outcome_type o;
      if (rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result word, step %0d", $time, rsp_step_number);
            error_count++;
         end else begin
            o = pending_outcomes.pop_front();
            check_field("accepted", 64'(o.accepted), 64'(rsp_accepted));
            check_field("step_number", 64'(o.step), 64'(rsp_step_number));
            check_field("kept_violations", 64'(o.viol), 64'(rsp_kept_violations));
            check_field("kept_costs", 64'(o.cost), 64'(rsp_kept_costs));
            check_field("step_temperature", 64'(o.temp), 64'(rsp_step_temperature));
            check_field("accept_probability", 64'(o.prob), 64'(rsp_accept_probability));
            words_checked++;
         end
      end
      if (hold_request) begin
         hold_request = 0;
         hold_left    = HOLD_LEN;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when no word moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed();
      // zero temperature after reset: equal, worse with negative sample, worse rejected
      send_move(16'd0, 20'd0, 18'sd0);
      send_move(16'd1, 20'd0, -18'sd1);
      send_move(16'd2, 20'd0, 18'sd0);
      send_move(16'hFFFF, 20'hFFFFF, 18'sd131071);
      send_move(16'hFFFF, 20'hFFFFF, -18'sd131072);
      send_move(16'd0, 20'd0, 18'sd65536);
      // unused mode codes behave as zero temperature
      write_register(CSR_MODE, CSR_DATA_W'(MODE_SPARE6));
      send_move(16'd0, 20'd5, -18'sd1);
      send_move(16'd0, 20'd9, 18'sd0);
      write_register(CSR_MODE, CSR_DATA_W'(MODE_SPARE7));
      send_move(16'd0, 20'd3, 18'sd0);
      // a write past the register list changes nothing
      write_register(CSR_UNUSED, 20'hFFFFF);
      send_move(16'd0, 20'd4, 18'sd0);
      // first log step runs at infinite temperature
      set_run(MODE_LOG50, 16'd0, 20'd10);
      send_move(16'd900, 20'd0, 18'sd65535);
      send_move(16'd901, 20'd3, 18'sd30000);
      send_move(16'd902, 20'd0, 18'sd100);
      // log schedule scaled by a zero initial score: always zero temperature
      set_run(MODE_LOGINIT, 16'd0, 20'd0);
      send_move(16'd0, 20'd1, 18'sd0);
      send_move(16'd0, 20'd1, -18'sd1);
      // largest initial score
      set_run(MODE_LOGINIT, 16'hFFFF, 20'hFFFFF);
      send_move(16'hFFFF, 20'hFFFFF, 18'sd0);
      send_move(16'd0, 20'd0, 18'sd0);
      send_move(16'hFFFF, 20'hFFFFF, 18'sd65535);
      set_run(MODE_LOG1, 16'd0, 20'd0);
      send_move(16'd0, 20'd0, 18'sd0);
      send_move(16'd0, 20'd1, 18'sd1);
      send_move(16'd0, 20'd1, 18'sd1);
   endtask

   // Every schedule in turn, rotating through the idling phases.
   task automatic test_schedules();
      logic [MODE_W-1:0] modes[6];
      int                idle_s[4], idle_r[4];
      modes  = '{MODE_ZERO, MODE_LOG50, MODE_LOG1, MODE_LOGINIT, MODE_GEO, MODE_REHEAT};
      idle_s = '{0, 73, 0, 25};
      idle_r = '{0, 0, 73, 25};
      for (int m = 0; m < 6; m++) begin
         set_run(modes[m], VIOL_W'($urandom_range(3)), COST_W'($urandom_range(2000)));
         for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_s[(p + m) % 4];
            recv_stall_pct = idle_r[(p + m) % 4];
            repeat (36) send_random_move();
         end
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // Hold the result side off while words keep coming, so the input stalls.
   task automatic test_backpressure();
      set_run(MODE_GEO, 16'd1, 20'd500);
      hold_request = 1;
      repeat (10) send_random_move();
   endtask

   // Pause the sender until everything is back, then carry on in the same run.
   task automatic test_drain_pause();
      set_run(MODE_REHEAT, 16'd0, 20'd100);
      repeat (12) send_random_move();
      drain_results();
      repeat (12) send_random_move();
   endtask

   initial begin
      sched_mode = MODE_ZERO;
      start_viol = '0;
      start_cost = '0;
      restart_annealing();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_schedules();
      test_backpressure();
      test_drain_pause();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d of %0d words across all six schedules and spare modes,",
               words_checked, words_sent);
      $display("with %0d worse moves accepted by the threshold test.", uphill_accepts);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/aas_pkg.sv
rtl/core/aas_div.sv
rtl/core/aas_queue.sv
rtl/core/aas_front.sv
rtl/core/aas_back.sv
rtl/core/annealing_schedule_and_acceptance.sv
rtl/core/aas_checker.sv
test/testbench.sv
